FILE: hw/rtl/ama_pkg.sv
// Shared constants for the altitude moving average block.
package ama_pkg;

    localparam int DEF_WINDOW_DEPTH = 16;
    localparam int DEF_SPAN_COUNTS  = 1240;
    localparam int DEF_SAMPLE_BITS  = 12;

    localparam int MEAN_BITS = 12;
    localparam int PCT_BITS  = 7;
    localparam int PCT_SCALE = 100;
    localparam int PCT_MAX   = 100;

endpackage

FILE: hw/rtl/ama_cell.sv
// One storage cell of the sample window chain.
module ama_cell
    import ama_pkg::*;
#(
    parameter int W = DEF_SAMPLE_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         shift_en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] data_reg;
    logic [W-1:0] data_next;

    assign data_next = shift_en ? d : data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign q = data_reg;

endmodule

FILE: hw/rtl/ama_cdiv.sv
// Two-stage divider by a constant: reciprocal multiply, then a one-step correction.
module ama_cdiv
    import ama_pkg::*;
#(
    parameter int XW      = 16,
    parameter int QW      = 12,
    parameter int TW      = 1,
    parameter int DIVISOR = DEF_WINDOW_DEPTH
) (
    input  logic          clk,
    input  logic          en1,
    input  logic          en2,
    input  logic [XW-1:0] dividend,
    input  logic [TW-1:0] tag_in,
    output logic [QW-1:0] quotient,
    output logic [TW-1:0] tag_out
);

    localparam int unsigned RECIP = (1 << XW) / DIVISOR;
    localparam int PW = 2 * XW + 1;

    logic [PW-1:0] prod;
    logic [QW-1:0] q_est_next;
    logic [XW-1:0] x1_reg;
    logic [QW-1:0] q1_reg;
    logic [TW-1:0] t1_reg;

    logic [XW-1:0] qd;
    logic [XW-1:0] rem;
    logic [QW-1:0] q_next;
    logic [QW-1:0] q2_reg;
    logic [TW-1:0] t2_reg;

    // The reciprocal is rounded down, so the estimate is the quotient or one less.
    assign prod       = PW'(dividend) * PW'(RECIP);
    assign q_est_next = QW'(prod >> XW);

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            x1_reg <= dividend;
            q1_reg <= q_est_next;
            t1_reg <= tag_in;
        end
    end

    assign qd     = XW'(q1_reg) * XW'(DIVISOR);
    assign rem    = x1_reg - qd;
    assign q_next = (rem >= XW'(DIVISOR)) ? q1_reg + QW'(1) : q1_reg;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            q2_reg <= q_next;
            t2_reg <= t1_reg;
        end
    end

    assign quotient = q2_reg;
    assign tag_out  = t2_reg;

endmodule

FILE: hw/rtl/altitude_moving_average.sv
// Top level of the altitude moving average with a landed reference level.
//
//   Channel  Handshake             Payload
//   input    in_valid / in_ready   sample
//   output   out_valid / out_ready mean_level, altitude_percent, reference_ready
//
// One sample is taken per cycle while in_ready is high; a full pipeline held by out_ready stalls it.
// The window is a shift chain of WINDOW_DEPTH cells with a running sum.
// The mean and the percent each go through a two-stage constant divider.
// Reset clears the cells, the sum, the sample count and the reference at once.
// Every stage holds its transaction when the next one is full, and bubbles close up.
module altitude_moving_average
    import ama_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
    parameter int SPAN_COUNTS  = DEF_SPAN_COUNTS,
    parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [MEAN_BITS-1:0]   mean_level,
    output logic [PCT_BITS-1:0]    altitude_percent,
    output logic                   reference_ready
);

    localparam int SB     = SAMPLE_BITS;
    localparam int SW     = SB + $clog2(WINDOW_DEPTH);
    localparam int LATCH  = 2 * WINDOW_DEPTH;
    localparam int CW     = $clog2(LATCH + 1);
    localparam int XP     = $clog2(PCT_SCALE * SPAN_COUNTS);
    localparam int PTW    = SB + 3;
    localparam int STAGES = 7;

    // Handshake chain over the pipeline stages.
    logic [STAGES:1]   vld_reg;
    logic [STAGES:1]   vld_next;
    logic [STAGES+1:1] rdy;
    logic              accept;

    always_comb
    begin
        rdy[STAGES+1] = out_ready;
        for (int k = STAGES; k >= 1; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        vld_next[1] = rdy[1] ? in_valid : vld_reg[1];
        for (int k = 2; k <= STAGES; k++)
        begin
            vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    assign in_ready = rdy[1];
    assign accept   = in_valid && rdy[1];

    // Sample window as a chain of cells; the last cell holds the oldest sample.
    logic [SB-1:0] chain [WINDOW_DEPTH];

    for (genvar i = 0; i < WINDOW_DEPTH; i++)
    begin : g_cell
        ama_cell #(
            .W (SB)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (accept),
            .d        ((i == 0) ? sample : chain[(i == 0) ? 0 : i - 1]),
            .q        (chain[i])
        );
    end

    logic [SW-1:0] sum_reg;
    logic [SW-1:0] sum_next;
    logic [CW-1:0] seen_reg;
    logic [CW-1:0] seen_next;
    logic          latch_in;

    assign sum_next  = accept ? sum_reg - SW'(chain[WINDOW_DEPTH-1]) + SW'(sample) : sum_reg;
    assign latch_in  = (seen_reg == CW'(LATCH - 1));
    assign seen_next = (accept && seen_reg != CW'(LATCH)) ? seen_reg + CW'(1) : seen_reg;

    // Stage 1: rounded dividend for the mean.
    logic [SW-1:0] p1_x_reg;
    logic          p1_latch_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            p1_x_reg     <= sum_reg - SW'(chain[WINDOW_DEPTH-1]) + SW'(sample)
                            + SW'(WINDOW_DEPTH / 2);
            p1_latch_reg <= latch_in;
        end
    end

    // Stages 2 and 3: mean of the window.
    logic [SB-1:0] mean_q;
    logic          mean_latch;

    ama_cdiv #(
        .XW      (SW),
        .QW      (SB),
        .TW      (1),
        .DIVISOR (WINDOW_DEPTH)
    ) u_mean_div (
        .clk      (clk),
        .en1      (rdy[2]),
        .en2      (rdy[3]),
        .dividend (p1_x_reg),
        .tag_in   (p1_latch_reg),
        .quotient (mean_q),
        .tag_out  (mean_latch)
    );

    // Stage 4: difference to the landed reference and the reference latch.
    logic [SB-1:0] landed_reg;
    logic [SB-1:0] landed_next;
    logic          landed_valid_reg;
    logic          landed_valid_next;
    logic          take4;
    logic          above;
    logic [SB-1:0] diff;
    logic          sat;
    logic [XP-1:0] pct_x;
    logic          item_ready;

    assign take4      = vld_reg[3] && rdy[4];
    assign above      = landed_valid_reg && (landed_reg > mean_q);
    assign diff       = landed_reg - mean_q;
    assign sat        = (32'(diff) >= 32'(SPAN_COUNTS));
    assign pct_x      = XP'(32'(diff) * 32'(PCT_SCALE));
    assign item_ready = landed_valid_reg || mean_latch;

    assign landed_next       = (take4 && mean_latch) ? mean_q : landed_reg;
    assign landed_valid_next = landed_valid_reg || (take4 && mean_latch);

    logic [XP-1:0]  p4_x_reg;
    logic [PTW-1:0] p4_tag_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            p4_x_reg   <= pct_x;
            p4_tag_reg <= {mean_q, item_ready, !above, sat};
        end
    end

    // Stages 5 and 6: percent of span.
    logic [PCT_BITS-1:0] pct_q;
    logic [PTW-1:0]      pct_tag;

    ama_cdiv #(
        .XW      (XP),
        .QW      (PCT_BITS),
        .TW      (PTW),
        .DIVISOR (SPAN_COUNTS)
    ) u_pct_div (
        .clk      (clk),
        .en1      (rdy[5]),
        .en2      (rdy[6]),
        .dividend (p4_x_reg),
        .tag_in   (p4_tag_reg),
        .quotient (pct_q),
        .tag_out  (pct_tag)
    );

    // Stage 7: output register.
    logic [MEAN_BITS-1:0] out_mean_reg;
    logic [PCT_BITS-1:0]  out_pct_reg;
    logic                 out_ref_reg;
    logic [PCT_BITS-1:0]  pct_final;

    always_comb
    begin
        if (pct_tag[1])
        begin
            pct_final = '0;
        end
        else if (pct_tag[0])
        begin
            pct_final = PCT_BITS'(PCT_MAX);
        end
        else
        begin
            pct_final = pct_q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[7])
        begin
            out_mean_reg <= MEAN_BITS'(pct_tag[PTW-1:3]);
            out_pct_reg  <= pct_final;
            out_ref_reg  <= pct_tag[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg          <= '0;
            sum_reg          <= '0;
            seen_reg         <= '0;
            landed_reg       <= '0;
            landed_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg          <= vld_next;
            sum_reg          <= sum_next;
            seen_reg         <= seen_next;
            landed_reg       <= landed_next;
            landed_valid_reg <= landed_valid_next;
        end
    end

    assign out_valid        = vld_reg[STAGES];
    assign mean_level       = out_mean_reg;
    assign altitude_percent = out_pct_reg;
    assign reference_ready  = out_ref_reg;

endmodule
